/* hw/rtl/rxs_pkg.sv */
// ----------------------------------------------------------------------------
// rxs_pkg
// Shared types and constants for the record exchange sorter.
// ----------------------------------------------------------------------------
package rxs_pkg;

    localparam int KEY_W  = 32;
    localparam int TAG_W  = 8;
    localparam int DATA_W = KEY_W + TAG_W;

    // One stored record: key in the low bits, tag above it
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } record_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_I,
        ST_LD_I,
        ST_CMP,
        ST_OUT
    } seq_state_t;

endpackage

/* hw/rtl/rxs_ram.sv */
// ----------------------------------------------------------------------------
// rxs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rxs_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/record_exchange_sort_by_key.sv */
// Timing: records load at one item per cycle; after the item marked last,
// each pass i reads slot i (ST_RD_I, ST_LD_I), compares it with slots i+1 up
// to n-1 in ST_CMP and offers the pass minimum in ST_OUT, for a set of n records.
// Throughput: one input item per cycle while loading; after the last item the
// input is held off until the last sorted item is taken, output stalls included.
// Reset (aresetn low, synchronous) empties the set and returns to loading;
// the record RAM is not cleared.
// ----------------------------------------------------------------------------
// record_exchange_sort_by_key
// Collects up to MAX_RECORDS key/tag records, exchange-sorts them by key in
// place with one shared comparator, and streams them out in ascending order.
// ----------------------------------------------------------------------------
module record_exchange_sort_by_key #(
    parameter int MAX_RECORDS = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Input records
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [rxs_pkg::DATA_W-1:0] s_tdata,  // [31:0] salary_key, [39:32] record_tag
    input  logic                     s_tlast,    // last_item
    // Sorted records
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [rxs_pkg::DATA_W-1:0] m_tdata,  // [31:0] sorted_key, [39:32] sorted_tag
    output logic                     m_tlast,    // final_result
    output logic                     m_tuser     // [0] overflow_seen
);

    import rxs_pkg::*;

    localparam int IDX_W = $clog2(MAX_RECORDS);
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             drop_reg, drop_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    record_t          cur_reg, cur_next;

    logic             s_fire, m_fire;
    logic             store_full;
    logic [CNT_W-1:0] i_inc, j_inc;
    logic             swap;
    logic             final_out;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    record_t          ram_wdata, ram_rdata;

    assign s_fire     = s_tvalid && s_tready;
    assign m_fire     = m_tvalid && m_tready;
    assign store_full = (fill_reg >= CNT_W'(MAX_RECORDS));
    assign i_inc      = i_reg + CNT_W'(1);
    assign j_inc      = j_reg + CNT_W'(1);
    assign swap       = (cur_reg.key > ram_rdata.key);
    assign final_out  = (i_inc == fill_reg);

    rxs_ram #(
        .WIDTH ($bits(record_t)),
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_fire && s_tlast) begin
                    state_next = ST_RD_I;
                end
            end
            ST_RD_I: begin
                state_next = ST_LD_I;
            end
            ST_LD_I: begin
                state_next = (i_inc < fill_reg) ? ST_CMP : ST_OUT;
            end
            ST_CMP: begin
                if (!(j_inc < fill_reg)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_fire) begin
                    state_next = final_out ? ST_LOAD : ST_RD_I;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Handshake and RAM control
    always_comb begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = fill_reg[IDX_W-1:0];
        ram_wdata = s_tdata;
        ram_raddr = i_reg[IDX_W-1:0];
        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                ram_we   = s_fire && !store_full;
            end
            ST_RD_I: begin
                ram_raddr = i_reg[IDX_W-1:0];
            end
            ST_LD_I: begin
                ram_raddr = i_inc[IDX_W-1:0];
            end
            ST_CMP: begin
                // Hand the larger key back to slot j, read ahead to j+1
                ram_we    = swap;
                ram_waddr = j_reg[IDX_W-1:0];
                ram_wdata = cur_reg;
                ram_raddr = j_inc[IDX_W-1:0];
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        fill_next = fill_reg;
        drop_next = drop_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        cur_next  = cur_reg;
        case (state_reg)
            ST_LOAD: begin
                i_next = '0;
                if (s_fire) begin
                    if (store_full) begin
                        drop_next = 1'b1;
                    end else begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
            end
            ST_LD_I: begin
                // cur_reg takes slot i and keeps the smallest record of the pass so far
                cur_next = ram_rdata;
                j_next   = i_inc;
            end
            ST_CMP: begin
                if (swap) begin
                    cur_next = ram_rdata;
                end
                j_next = j_inc;
            end
            ST_OUT: begin
                if (m_fire) begin
                    i_next = i_inc;
                    if (final_out) begin
                        fill_next = '0;
                        drop_next = 1'b0;
                    end
                end
            end
            default: begin
                cur_next = cur_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            fill_reg  <= '0;
            drop_reg  <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            drop_reg  <= drop_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    // Current minimum record, no reset
    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    assign m_tdata = cur_reg;
    assign m_tlast = final_out;
    assign m_tuser = drop_reg;

endmodule

/* verif/rxs_sort_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxs_sort_checker
// Watches both stream channels of the record sorter. It keeps its own copy of
// the record set, sorts it when the item marked last is taken, and compares
// every sorted item that leaves the block against the oldest expected one.
// ----------------------------------------------------------------------------
module rxs_sort_checker #(
    parameter int CAPACITY = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [rxs_pkg::DATA_W-1:0] s_tdata,   // [31:0] salary_key, [39:32] record_tag
    input  logic                       s_tlast,   // last_item
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [rxs_pkg::DATA_W-1:0] m_tdata,   // [31:0] sorted_key, [39:32] sorted_tag
    input  logic                       m_tlast,   // final_result
    input  logic                       m_tuser,   // [0] overflow_seen
    output int                         fail_count,
    output int                         pending_count
);

    import rxs_pkg::*;

    // One expected output item
    typedef struct packed {
        record_t rec;
        logic    is_final;
        logic    overflow;
    } sorted_item_t;

    record_t        set_recs [CAPACITY];
    int unsigned    set_size;
    logic           set_dropped;
    sorted_item_t   sorted_q [$];
    int             errors;

    // Exchange-sort the held set in place, then queue it in ascending order
    function automatic void sort_and_release();
        int unsigned  n;
        int unsigned  i;
        int unsigned  j;
        record_t      swap;
        sorted_item_t item;
        n = set_size;
        for (i = 0; i + 1 < n; i++) begin
            for (j = i + 1; j < n; j++) begin
                if (set_recs[i].key > set_recs[j].key) begin
                    swap        = set_recs[i];
                    set_recs[i] = set_recs[j];
                    set_recs[j] = swap;
                end
            end
        end
        for (i = 0; i < n; i++) begin
            item.rec      = set_recs[i];
            item.is_final = (i + 1 == n);
            item.overflow = set_dropped;
            sorted_q.push_back(item);
        end
        set_size    = 0;
        set_dropped = 1'b0;
    endfunction

    // Count a failure and report it
    function automatic void flag_field(string field, logic [31:0] want, logic [31:0] got);
        errors++;
        $display("%0t: %s expected %h, got %h", $time, field, want, got);
    endfunction

    always @(posedge aclk) begin : watch
        sorted_item_t want;
        record_t      got;
        if (!aresetn) begin
            set_size    = 0;
            set_dropped = 1'b0;
            sorted_q.delete();
        end else begin
            // Hold an incoming record, or drop it when the set is full
            if (s_tvalid && s_tready) begin
                if (set_size < CAPACITY) begin
                    set_recs[set_size] = s_tdata;
                    set_size++;
                end else begin
                    set_dropped = 1'b1;
                end
                if (s_tlast)
                    sort_and_release();
            end
            // Compare a leaving item against the oldest expectation
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (sorted_q.size() == 0) begin
                    errors++;
                    $display("%0t: expected no item, got key %h tag %h last %b user %b",
                             $time, got.key, got.tag, m_tlast, m_tuser);
                end else begin
                    want = sorted_q.pop_front();
                    if (got.key !== want.rec.key)
                        flag_field("sorted_key", want.rec.key, got.key);
                    if (got.tag !== want.rec.tag)
                        flag_field("sorted_tag", 32'(want.rec.tag), 32'(got.tag));
                    if (m_tlast !== want.is_final)
                        flag_field("final_result", 32'(want.is_final), 32'(m_tlast));
                    if (m_tuser !== want.overflow)
                        flag_field("overflow_seen", 32'(want.overflow), 32'(m_tuser));
                end
            end
        end
        fail_count    <= errors;
        pending_count <= sorted_q.size();
    end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives record sets into the exchange sorter: a few hand-picked sets covering
// field extremes, equal keys and reversed input, then random sets of mixed
// size including full and overflowing ones, with random gaps on both sides
// and long output stalls. A side checker predicts and compares every item.
// ----------------------------------------------------------------------------
module testbench;

    import rxs_pkg::*;

    localparam int CAPACITY     = 32;
    localparam int ITEM_TARGET  = 410;
    localparam int HOLD_CYCLES  = 800;
    localparam int DRAIN_CYCLES = 700;

    typedef enum int {
        KEYS_WIDE,
        KEYS_FEW,
        KEYS_EDGE
    } key_mode_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;   // [31:0] salary_key, [39:32] record_tag
    logic              s_tlast  = 1'b0; // last_item
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;         // [31:0] sorted_key, [39:32] sorted_tag
    logic              m_tlast;         // final_result
    logic              m_tuser;         // [0] overflow_seen

    int fail_count;
    int pending_count;
    int items_sent    = 0;
    bit steady_sender = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    record_exchange_sort_by_key #(
        .MAX_RECORDS (CAPACITY)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    rxs_sort_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Offer one record after a random gap and hold it until taken
    task automatic send_record(input logic [31:0] key, input logic [7:0] tag,
                               input logic last);
        int gap;
        gap = steady_sender ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tag, key};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    function automatic logic [31:0] draw_key(key_mode_t mode);
        case (mode)
            KEYS_FEW:  return $urandom_range(0, 7);
            KEYS_EDGE: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h0000_0000;
                    1:       return 32'hFFFF_FFFF;
                    2:       return 32'h7FFF_FFFF;
                    3:       return 32'h8000_0000;
                    default: return 32'hFFFF_FFFC + $urandom_range(0, 3);
                endcase
            end
            default:   return $urandom;
        endcase
    endfunction

    // Send a whole set; the final item carries the last mark
    task automatic send_set(input int n, input key_mode_t mode);
        int k;
        for (k = 0; k < n; k++)
            send_record(draw_key(mode), 8'($urandom_range(0, 255)), k == n - 1);
    endtask

    // Sender side: reset, directed sets, random sets, then wait for the tail
    initial begin : stimulus
        int        n;
        int        k;
        key_mode_t mode;
        aresetn <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single-record sets at both field extremes
        send_record(32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_record(32'h0000_0000, 8'h00, 1'b1);
        // Equal keys: order follows the swap sequence
        for (k = 1; k <= 5; k++)
            send_record(32'd5, k[7:0], k == 5);
        // Key extremes mixed
        send_record(32'hFFFF_FFFF, 8'hA5, 1'b0);
        send_record(32'h0000_0000, 8'h5A, 1'b0);
        send_record(32'h8000_0000, 8'h0F, 1'b0);
        send_record(32'h7FFF_FFFF, 8'hF0, 1'b0);
        send_record(32'h0000_0001, 8'h81, 1'b0);
        send_record(32'hFFFF_FFFE, 8'h7E, 1'b1);
        // Reversed input
        for (k = 4; k >= 1; k--)
            send_record(k * 32'd10, k[7:0], k == 1);

        // Store full: a dropped record still ends the set
        send_set(CAPACITY + 1, KEYS_WIDE);
        send_set(CAPACITY + 8, KEYS_FEW);

        // Random sets, mostly small, some full or overflowing
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 19))
                0:       n = CAPACITY;
                1:       n = $urandom_range(CAPACITY + 1, CAPACITY + 6);
                default: n = $urandom_range(1, 12);
            endcase
            mode          = key_mode_t'($urandom_range(0, 2));
            steady_sender = ($urandom_range(0, 3) == 0);
            send_set(n, mode);
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // Drain everything expected, then watch for stray items
        do @(posedge aclk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("record_exchange_sort_by_key: match");
        end else begin
            $display("record_exchange_sort_by_key: mismatch");
        end
        $finish;
    end

    // Receiver side: random gaps, steady stretches and two long stalls
    initial begin : drain
        int gap;
        int taken;
        bit steady;
        taken  = 0;
        steady = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken == 60 || taken == 260) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (taken % 32 == 0)
                steady = ($urandom_range(0, 2) == 0);
            gap = steady ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    // Hard stop if the run hangs
    initial begin : watchdog
        #4_000_000;
        $display("record_exchange_sort_by_key: mismatch");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/rxs_pkg.sv
hw/rtl/rxs_ram.sv
hw/rtl/record_exchange_sort_by_key.sv
verif/rxs_sort_checker.sv
verif/testbench.sv
